[design/gmb_pkg.sv]
// Shared types and constants for the glyph point blend, scale and bounding box block.
// Holds the sequencer state encoding, register indexes and bounding box reset values.
// No dependencies.
package gmb_pkg;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_BX   = 6'b000010,
        ST_BY   = 6'b000100,
        ST_SX   = 6'b001000,
        ST_SY   = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_BLEND_WEIGHT  = 3'd0;
    localparam reg_idx_t REG_TARGET_HEIGHT = 3'd1;
    localparam reg_idx_t REG_MIRROR_Y      = 3'd2;
    localparam reg_idx_t REG_ORIGIN_X      = 3'd3;
    localparam reg_idx_t REG_ORIGIN_Y      = 3'd4;

    localparam logic signed [15:0] BOX_MIN_INIT = 16'sh7FFF;
    localparam logic signed [15:0] BOX_MAX_INIT = 16'sh8000;

    localparam logic [8:0]  WEIGHT_INIT = 9'd0;
    localparam logic [9:0]  HEIGHT_INIT = 10'd44;

    typedef struct packed {
        logic go;
        logic busy;
    } div_ctl_t;

endpackage

[design/gmb_div.sv]
// Scale factor unit: divides a NUM_W-bit numerator by constant DEN; registers numerator, then quotient.
// The quotient comes from a multiplication by a precomputed reciprocal; uses gmb_pkg for its control struct.
module gmb_div
    import gmb_pkg::*;
#(
    parameter int NUM_W = 18,
    parameter int DEN   = 44
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NUM_W-1:0] num,
    output div_ctl_t         ctl,
    output logic [NUM_W-1:0] quot
);

    localparam int RCP_W  = NUM_W + 1;
    localparam int PROD_W = NUM_W + RCP_W;
    localparam int SHIFT  = NUM_W + $clog2(DEN);
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((longint'(1) << SHIFT) + longint'(DEN) - 1) / longint'(DEN));

    logic              busy_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  quot_reg;
    logic [PROD_W-1:0] prod_full;

    assign prod_full = PROD_W'(num_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            num_reg <= num;
        end
        if (busy_reg)
        begin
            quot_reg <= NUM_W'(prod_full >> SHIFT);
        end
    end

    assign ctl.go   = go;
    assign ctl.busy = busy_reg;
    assign quot     = quot_reg;

endmodule

[design/gmb_mul.sv]
// Shared signed multiplier with a registered product and a load enable.
// Used for both the weight blend and the scale step; no package dependencies.
module gmb_mul #(
    parameter int A_W = 19,
    parameter int B_W = 19
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [A_W-1:0]    a,
    input  logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W-1:0] p
);

    logic signed [A_W+B_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

[design/glyph_point_blend_scale_bbox.sv]
// A beat steps the sequencer through BX, BY, SX, SY and FIN; no new beat is taken until it is back in IDLE.
// Both coordinates share one multiplier: two blend products, then two scale products.
// A finished point may wait in the output register while the next point is worked on.
// After reset and after each target_height write the scale is rebuilt by a reciprocal
// multiplication, which holds the input stalled while it runs.
// Reset is asynchronous and active low; it loads register defaults and clears the box.
module glyph_point_blend_scale_bbox
    import gmb_pkg::*;
#(
    parameter int FRAC_BITS  = 8,
    parameter int BOX_HEIGHT = 44
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         light_x,
    input  logic [7:0]         light_y,
    input  logic [7:0]         heavy_x,
    input  logic [7:0]         heavy_y,
    input  logic               glyph_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pix_x,
    output logic signed [15:0] pix_y,
    output logic signed [15:0] box_min_x,
    output logic signed [15:0] box_min_y,
    output logic signed [15:0] box_max_x,
    output logic signed [15:0] box_max_y,
    output logic               box_final
);

    localparam int SCALE_W = 10 + FRAC_BITS;
    localparam int D_W     = ((FRAC_BITS + 9 > 17) ? FRAC_BITS + 9 : 17) + 2;
    localparam int B_W     = SCALE_W + 1;
    localparam int P_W     = D_W + B_W;
    localparam int SH      = 2 * FRAC_BITS;
    localparam logic [P_W-1:0] RND = P_W'(1) << (SH - 1);

    // Configuration registers.
    logic [8:0] blend_weight_reg;
    logic [9:0] target_height_reg;
    logic       mirror_y_reg;
    logic [7:0] origin_x_reg;
    logic [7:0] origin_y_reg;
    logic       cfg_wr;
    reg_idx_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_weight_reg  <= WEIGHT_INIT;
            target_height_reg <= HEIGHT_INIT;
            mirror_y_reg      <= 1'b0;
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_BLEND_WEIGHT:  blend_weight_reg  <= pwdata[8:0];
                REG_TARGET_HEIGHT: target_height_reg <= pwdata[9:0];
                REG_MIRROR_Y:      mirror_y_reg      <= pwdata[0];
                REG_ORIGIN_X:      origin_x_reg      <= pwdata[7:0];
                REG_ORIGIN_Y:      origin_y_reg      <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_BLEND_WEIGHT:  prdata = {23'd0, blend_weight_reg};
            REG_TARGET_HEIGHT: prdata = {22'd0, target_height_reg};
            REG_MIRROR_Y:      prdata = {31'd0, mirror_y_reg};
            REG_ORIGIN_X:      prdata = {24'd0, origin_x_reg};
            REG_ORIGIN_Y:      prdata = {24'd0, origin_y_reg};
            default:           prdata = '0;
        endcase
    end

    // Scale factor: (target_height << FRAC_BITS) / BOX_HEIGHT.
    logic               div_go_reg;
    div_ctl_t           div_ctl;
    logic [SCALE_W-1:0] scale;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_go_reg <= 1'b1;
        end
        else
        begin
            div_go_reg <= cfg_wr && (cfg_idx == REG_TARGET_HEIGHT);
        end
    end

    gmb_div #(
        .NUM_W (SCALE_W),
        .DEN   (BOX_HEIGHT)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go_reg),
        .num   ({target_height_reg, FRAC_BITS'(0)}),
        .ctl   (div_ctl),
        .quot  (scale)
    );

    // Sequencer and datapath.
    state_t state_reg, state_next;
    logic [7:0] lx_reg, ly_reg, hx_reg, hy_reg;
    logic       last_reg;
    logic signed [D_W-1:0] dx_reg, dx_next;
    logic signed [D_W-1:0] dy_reg, dy_next;
    logic signed [15:0]    px_reg, px_next;

    logic                  in_acc;
    logic                  out_load;
    logic                  mul_en;
    logic signed [D_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [P_W-1:0] prod;
    logic [P_W-1:0]        prod_rnd;
    logic signed [15:0]    py_raw;
    logic signed [15:0]    py_fin;
    logic signed [8:0]     diff_x, diff_y;
    logic signed [D_W-1:0] blend_cur;
    logic [7:0]            blend_lo;
    logic [7:0]            blend_org;

    assign in_stall = (state_reg != ST_IDLE) || div_go_reg || div_ctl.busy;
    assign in_acc   = in_valid && !in_stall;
    assign out_load = (state_reg == ST_FIN) && (!out_valid || !out_stall);

    assign diff_x = $signed({1'b0, hx_reg}) - $signed({1'b0, lx_reg});
    assign diff_y = $signed({1'b0, hy_reg}) - $signed({1'b0, ly_reg});

    assign blend_lo  = (state_reg == ST_BY) ? lx_reg : ly_reg;
    assign blend_org = (state_reg == ST_BY) ? origin_x_reg : origin_y_reg;
    assign blend_cur = $signed(D_W'({blend_lo, FRAC_BITS'(0)}))
                     + $signed(prod[D_W-1:0])
                     - $signed(D_W'({blend_org, FRAC_BITS'(0)}));

    assign prod_rnd = prod + RND;
    assign py_raw   = $signed(prod_rnd[SH+15:SH]);
    assign py_fin   = mirror_y_reg ? ($signed({6'd0, target_height_reg}) - py_raw) : py_raw;

    always_comb
    begin
        mul_en = 1'b1;
        unique case (state_reg)
            ST_BX:
            begin
                mul_a = D_W'(diff_x);
                mul_b = $signed(B_W'(blend_weight_reg));
            end
            ST_BY:
            begin
                mul_a = D_W'(diff_y);
                mul_b = $signed(B_W'(blend_weight_reg));
            end
            ST_SX:
            begin
                mul_a = dx_reg;
                mul_b = $signed(B_W'(scale));
            end
            ST_SY:
            begin
                mul_a = dy_reg;
                mul_b = $signed(B_W'(scale));
            end
            default:
            begin
                mul_en = 1'b0;
                mul_a  = dy_reg;
                mul_b  = $signed(B_W'(scale));
            end
        endcase
    end

    gmb_mul #(
        .A_W (D_W),
        .B_W (B_W)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    always_comb
    begin
        state_next = state_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        px_next    = px_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_BX;
            ST_BX:   state_next = ST_BY;
            ST_BY:
            begin
                dx_next    = blend_cur;
                state_next = ST_SX;
            end
            ST_SX:
            begin
                dy_next    = blend_cur;
                state_next = ST_SY;
            end
            ST_SY:
            begin
                px_next    = $signed(prod_rnd[SH+15:SH]);
                state_next = ST_FIN;
            end
            ST_FIN:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        px_reg <= px_next;
        if (in_acc)
        begin
            lx_reg   <= light_x;
            ly_reg   <= light_y;
            hx_reg   <= heavy_x;
            hy_reg   <= heavy_y;
            last_reg <= glyph_end;
        end
    end

    // Running bounding box and output register.
    logic signed [15:0] run_min_x_reg, run_min_y_reg, run_max_x_reg, run_max_y_reg;
    logic signed [15:0] min_x_new, min_y_new, max_x_new, max_y_new;
    logic               out_valid_reg;
    logic signed [15:0] pix_x_reg, pix_y_reg;
    logic signed [15:0] box_min_x_reg, box_min_y_reg, box_max_x_reg, box_max_y_reg;
    logic               box_final_reg;

    assign min_x_new = (px_reg < run_min_x_reg) ? px_reg : run_min_x_reg;
    assign max_x_new = (px_reg > run_max_x_reg) ? px_reg : run_max_x_reg;
    assign min_y_new = (py_fin < run_min_y_reg) ? py_fin : run_min_y_reg;
    assign max_y_new = (py_fin > run_max_y_reg) ? py_fin : run_max_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_x_reg <= BOX_MIN_INIT;
            run_min_y_reg <= BOX_MIN_INIT;
            run_max_x_reg <= BOX_MAX_INIT;
            run_max_y_reg <= BOX_MAX_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    run_min_x_reg <= BOX_MIN_INIT;
                    run_min_y_reg <= BOX_MIN_INIT;
                    run_max_x_reg <= BOX_MAX_INIT;
                    run_max_y_reg <= BOX_MAX_INIT;
                end
                else
                begin
                    run_min_x_reg <= min_x_new;
                    run_min_y_reg <= min_y_new;
                    run_max_x_reg <= max_x_new;
                    run_max_y_reg <= max_y_new;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pix_x_reg     <= px_reg;
            pix_y_reg     <= py_fin;
            box_min_x_reg <= min_x_new;
            box_min_y_reg <= min_y_new;
            box_max_x_reg <= max_x_new;
            box_max_y_reg <= max_y_new;
            box_final_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pix_x     = pix_x_reg;
    assign pix_y     = pix_y_reg;
    assign box_min_x = box_min_x_reg;
    assign box_min_y = box_min_y_reg;
    assign box_max_x = box_max_x_reg;
    assign box_max_y = box_max_y_reg;
    assign box_final = box_final_reg;

    // Checks on the sequencer, the running box and the input stall during a scale rebuild.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_BX))
        else $error("accepted beat did not start the sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_valid && out_stall) |=> (state_reg == ST_FIN))
        else $error("result left the sequencer while the output was blocked");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (box_min_x <= box_max_x && box_min_y <= box_max_y))
        else $error("bounding box is inverted");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.busy |-> in_stall)
        else $error("input taken while the scale is being rebuilt");

endmodule
